>>> src/pcxrle_pkg.sv
// Shared constants and types of the PCX run-length scanline decoder.
package pcxrle_pkg;

  localparam logic [12:0] MAX_WIDTH    = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [7:0]  RUN_HDR_MIN  = 8'hC0;
  localparam logic [7:0]  ALPHA_VALUE  = 8'hFF;

  localparam logic [1:0]  CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0]  CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0]  CFG_LINE_STRIDE  = 2'd2;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Up to two run descriptors caused by one input byte: the decoded run and
  // the zero fill that closes a row when the data ends inside it.
  typedef struct packed {
    logic [7:0]  value;
    logic [11:0] row;
    logic [11:0] col_a;
    logic [12:0] len_a;
    logic        has_a;
    logic [11:0] col_b;
    logic [12:0] len_b;
    logic        has_b;
    logic        alpha;
    logic        complete;
  } run_pair_t;

endpackage

>>> src/pcxrle_fifo.sv
// Small descriptor queue between the byte parser and the output sequencer.
module pcxrle_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pcxrle_pkg::run_pair_t push_data,
  input  logic                  pop,
  output pcxrle_pkg::run_pair_t pop_data,
  output logic                  full,
  output logic                  empty
);

  pcxrle_pkg::run_pair_t mem_r [pcxrle_pkg::FIFO_DEPTH];
  logic [pcxrle_pkg::FIFO_AW-1:0] wr_ptr_r;
  logic [pcxrle_pkg::FIFO_AW-1:0] rd_ptr_r;
  logic [pcxrle_pkg::FIFO_AW:0]   count_r;

  assign full     = (count_r == (pcxrle_pkg::FIFO_AW+1)'(pcxrle_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> src/pcxrle_front.sv
// Byte parser: configuration registers, row and column tracking, run descriptors.
module pcxrle_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  input  logic                  in_end,
  output logic                  in_ready,
  input  logic                  fifo_full,
  output logic                  push,
  output pcxrle_pkg::run_pair_t push_data
);

  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [15:0] stride_r;

  logic [12:0] column_r, column_nxt;
  logic [12:0] row_r, row_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [5:0]  pending_r, pending_nxt;
  logic [15:0] padding_r, padding_nxt;
  logic        alpha_r, alpha_nxt;
  logic        finished_r, finished_nxt;

  logic        accept;
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic        is_hdr;
  logic        write_en;
  logic [12:0] want_a;
  logic [12:0] room_a;
  logic [12:0] len_a;
  logic [12:0] col_a;
  logic        awaiting_a;
  logic        line_end;
  logic [12:0] row_inc;
  logic [12:0] room_b;
  logic [15:0] w_ext;
  logic        data_used;
  logic        row_done;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && !fifo_full;

  assign w_eff = (width_r > pcxrle_pkg::MAX_WIDTH) ? pcxrle_pkg::MAX_WIDTH : width_r;
  assign h_eff = (height_r > pcxrle_pkg::MAX_HEIGHT) ? pcxrle_pkg::MAX_HEIGHT : height_r;
  assign w_ext = {3'b000, w_eff};

  // A header byte only loads the count; the pixels come with the next byte.
  assign is_hdr     = (in_byte >= pcxrle_pkg::RUN_HDR_MIN);
  assign write_en   = awaiting_r || !is_hdr;
  assign want_a     = awaiting_r ? {7'd0, pending_r} : 13'd1;
  assign room_a     = (column_r < w_eff) ? (w_eff - column_r) : 13'd0;
  assign len_a      = !write_en ? 13'd0 : ((want_a < room_a) ? want_a : room_a);
  assign col_a      = column_r + len_a;
  assign awaiting_a = !awaiting_r && is_hdr;
  assign line_end   = !awaiting_a && (col_a >= w_eff);
  assign row_inc    = row_r + 13'd1;
  assign room_b     = (col_a < w_eff) ? (w_eff - col_a) : 13'd0;

  always_comb begin
    column_nxt   = column_r;
    row_nxt      = row_r;
    awaiting_nxt = awaiting_r;
    pending_nxt  = pending_r;
    padding_nxt  = padding_r;
    alpha_nxt    = alpha_r;
    finished_nxt = finished_r;
    data_used    = 1'b0;
    row_done     = 1'b0;

    push_data          = '0;
    push_data.value    = in_byte;
    push_data.row      = row_r[11:0];
    push_data.col_a    = column_r[11:0];
    push_data.len_a    = len_a;
    push_data.col_b    = col_a[11:0];
    push_data.len_b    = room_b;

    if (accept && !finished_r) begin
      priority if (row_r >= h_eff) begin
        finished_nxt = 1'b1;
      end else if (padding_r != 16'd0) begin
        padding_nxt = padding_r - 16'd1;
      end else begin
        data_used       = 1'b1;
        awaiting_nxt    = awaiting_a;
        column_nxt      = col_a;
        push_data.has_a = (len_a != 13'd0);
        if (awaiting_a) begin
          pending_nxt = in_byte[5:0];
        end
        if (push_data.has_a && (in_byte == pcxrle_pkg::ALPHA_VALUE)) begin
          alpha_nxt = 1'b1;
        end
        if (line_end) begin
          column_nxt  = 13'd0;
          row_nxt     = row_inc;
          padding_nxt = (stride_r > w_ext) ? (stride_r - w_ext) : 16'd0;
          row_done    = 1'b1;
          if (row_inc >= h_eff) begin
            finished_nxt = 1'b1;
          end
        end
      end

      // Data that ends inside a row closes it with a run of zeros.
      if (in_end && !finished_nxt) begin
        if (data_used && !row_done) begin
          push_data.has_b = (room_b != 13'd0);
        end
        awaiting_nxt = 1'b0;
        finished_nxt = 1'b1;
      end
    end

    push_data.alpha    = alpha_nxt;
    push_data.complete = finished_nxt;
  end

  assign push = accept && (push_data.has_a || push_data.has_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 13'd1;
      height_r   <= 13'd1;
      stride_r   <= 16'd1;
      column_r   <= '0;
      row_r      <= '0;
      awaiting_r <= 1'b0;
      pending_r  <= '0;
      padding_r  <= '0;
      alpha_r    <= 1'b0;
      finished_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          pcxrle_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[12:0];
          pcxrle_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[12:0];
          pcxrle_pkg::CFG_LINE_STRIDE:  stride_r <= cfg_wdata;
          default: ;
        endcase
      end
      column_r   <= column_nxt;
      row_r      <= row_nxt;
      awaiting_r <= awaiting_nxt;
      pending_r  <= pending_nxt;
      padding_r  <= padding_nxt;
      alpha_r    <= alpha_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

>>> src/pcxrle_back.sv
// Output sequencer: unpacks queued descriptor pairs into single run transactions.
module pcxrle_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fifo_empty,
  input  pcxrle_pkg::run_pair_t fifo_head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  logic        valid_r;
  logic [7:0]  value_r;
  logic [11:0] col_r;
  logic [11:0] row_r;
  logic [12:0] len_r;
  logic        alpha_r;
  logic        complete_r;
  logic        last_r;
  logic        pend_r;
  logic [11:0] pend_col_r;
  logic [12:0] pend_len_r;
  logic        slot_free;

  assign slot_free = !valid_r || out_tready;
  assign pop       = slot_free && !pend_r && !fifo_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (slot_free) begin
      priority if (pend_r) begin
        valid_r <= 1'b1;
        pend_r  <= 1'b0;
      end else if (!fifo_empty) begin
        valid_r <= 1'b1;
        pend_r  <= fifo_head.has_a && fifo_head.has_b;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  // The zero fill keeps the row and flags of the run loaded just before it.
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_r) begin
        value_r <= 8'd0;
        col_r   <= pend_col_r;
        len_r   <= pend_len_r;
        last_r  <= 1'b1;
      end else if (!fifo_empty) begin
        value_r    <= fifo_head.has_a ? fifo_head.value : 8'd0;
        col_r      <= fifo_head.has_a ? fifo_head.col_a : fifo_head.col_b;
        len_r      <= fifo_head.has_a ? fifo_head.len_a : fifo_head.len_b;
        row_r      <= fifo_head.row;
        alpha_r    <= fifo_head.alpha;
        complete_r <= fifo_head.complete;
        last_r     <= !(fifo_head.has_a && fifo_head.has_b);
        pend_col_r <= fifo_head.col_b;
        pend_len_r <= fifo_head.len_b;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, len_r, row_r, col_r, value_r};
  assign out_tuser  = {complete_r, alpha_r};
  assign out_tlast  = last_r;

endmodule

>>> src/pcx_rle_scanline_decoder.sv
// PCX 8-bit run-length scanline decoder, top level.
// A run transaction passes through the descriptor queue and the output register before it is offered.
// Throughput: one compressed byte per cycle while the queue is not full; a byte that also
// closes its row with a zero fill yields two output transactions, absorbed by a four-entry queue.
// Reset (synchronous, rst_n low) empties the queue, clears position and flags,
// and sets width, height and stride to one.
module pcx_rle_scanline_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // run_value[7:0], run_column[19:8], run_row[31:20],
                                  // run_length[44:32], zero pad[47:45]
  output logic [1:0]  out_tuser,  // has_alpha[0], image_complete[1]
  output logic        out_tlast
);

  pcxrle_pkg::run_pair_t push_data;
  pcxrle_pkg::run_pair_t head_data;
  logic                  push;
  logic                  pop;
  logic                  fifo_full;
  logic                  fifo_empty;

  pcxrle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .in_ready  (in_tready),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  pcxrle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head_data),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  pcxrle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_head  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Every reported run writes at least one pixel.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[44:32] != 13'd0))
    else $error("run transaction with zero length");

  // A run never extends past the widest possible row.
  a_run_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (({1'b0, out_tdata[19:8]} + out_tdata[44:32]) <= pcxrle_pkg::MAX_WIDTH))
    else $error("run transaction crosses the row end");

  // A zero fill run is always the last transaction of its byte.
  a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && out_tdata[7:0] == 8'd0))
    else $error("second run of a byte is not a zero fill");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
